FILE: hw/rtl/sps_pkg.sv
// Shared constants, types and helpers for the sparse Pearson similarity unit.
package sps_pkg;

   localparam int MaxEntries = 1024;
   localparam int ItemBits   = 12;
   localparam int RatingBits = 5;
   localparam int RatingMax  = 31;
   localparam int AddrBits   = $clog2(MaxEntries);
   localparam int LenBits    = $clog2(MaxEntries + 1);
   localparam int SumBits    = 15;
   localparam int SqBits     = 20;
   localparam int VarBits    = 40;
   localparam int ProdBits   = 80;
   localparam int RootBits   = 40;
   localparam int NumBits    = 50;
   localparam int QuoBits    = 16;
   localparam int QOne       = 16384;

   localparam int ReqBits = 24;
   localparam int RspBits = 32;

   localparam logic ActLoad   = 1'b0;
   localparam logic ActStream = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;      // store entry, clear pair
      logic capture;   // latch streamed entry
      logic rd_req;    // read stored entry at pointer
      logic step;      // evaluate fetched stored entry
      logic fin_start; // start variance stage
      logic fin_mul;   // form products
      logic sqrt_init; // set up square root
      logic sqrt_step; // one root step
      logic div_init;  // set up divide
      logic div_step;  // one quotient step
      logic emit;      // load result register
      logic clear;     // clear pair accumulators
   } sps_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic walk_more; // pointer below length
      logic stop;      // fetched entry ends the walk
      logic rated;     // captured rating nonzero
      logic last;
      logic sqrt_done;
      logic div_done;
   } sps_sts_type;

   // Clamp rating to the allowed maximum
   function automatic logic [RatingBits-1:0] clamp_rating(input logic [RatingBits-1:0] r);
      clamp_rating = (r > RatingBits'(RatingMax)) ? RatingBits'(RatingMax) : r;
   endfunction

endpackage

FILE: hw/rtl/sps_ctrl.sv
// Controller state machine for the sparse Pearson similarity unit.
module sps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 req_action,
   input  logic                 rsp_busy,
   input  sps_pkg::sps_sts_type sts,
   output logic                 req_ready,
   output sps_pkg::sps_cmd_type cmd
);

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StWalk  = 4'd1;
   localparam logic [3:0] StRead  = 4'd2;
   localparam logic [3:0] StEval  = 4'd3;
   localparam logic [3:0] StFinA  = 4'd4;
   localparam logic [3:0] StFinB  = 4'd5;
   localparam logic [3:0] StSqrt  = 4'd6;
   localparam logic [3:0] StDivI  = 4'd7;
   localparam logic [3:0] StDiv   = 4'd8;
   localparam logic [3:0] StEmit  = 4'd9;
   localparam logic [3:0] StDecide= 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == StIdle);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               if (req_action == sps_pkg::ActLoad) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in = StDecide;
               end
            end
         end
         StDecide: begin
            if (sts.rated) state_in = StWalk;
            else if (sts.last) state_in = StFinA;
            else state_in = StIdle;
         end
         StWalk: begin
            if (sts.walk_more) begin
               cmd.rd_req = 1'b1;
               state_in = StRead;
            end else if (sts.last) state_in = StFinA;
            else state_in = StIdle;
         end
         StRead: state_in = StEval;
         StEval: begin
            cmd.step = 1'b1;
            if (sts.stop) state_in = sts.last ? StFinA : StIdle;
            else state_in = StWalk;
         end
         StFinA: begin
            cmd.fin_start = 1'b1;
            state_in = StFinB;
         end
         StFinB: begin
            cmd.fin_mul = 1'b1;
            state_in = StSqrt;
         end
         StSqrt: begin
            if (sts.sqrt_done) state_in = StDivI;
            else cmd.sqrt_step = 1'b1;
         end
         StDivI: begin
            cmd.div_init = 1'b1;
            state_in = StDiv;
         end
         StDiv: begin
            if (sts.div_done) state_in = StEmit;
            else cmd.div_step = 1'b1;
         end
         StEmit: begin
            if (!rsp_busy) begin
               cmd.emit  = 1'b1;
               cmd.clear = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      if (state_ff == StFinB) cmd.sqrt_init = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else       state_ff <= state_in;
   end

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == StIdle) else $error("emit not followed by idle");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.step && !cmd.sqrt_step) else $error("work while ready");
   a_read_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_req |=> state_ff == StRead) else $error("read sequence broken");

endmodule

FILE: hw/rtl/sps_datapath.sv
// Datapath: stored row, merge accumulators, square root and divider.
module sps_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  sps_pkg::sps_cmd_type           cmd,
   input  logic [sps_pkg::ItemBits-1:0]   in_item,
   input  logic [sps_pkg::RatingBits-1:0] in_rating,
   input  logic                           in_last,
   input  logic                           in_suppress,
   output sps_pkg::sps_sts_type           sts,
   output logic signed [15:0]             sim,
   output logic [sps_pkg::LenBits-1:0]    count,
   output logic                           undef
);

   localparam int AB = sps_pkg::AddrBits;
   localparam int LB = sps_pkg::LenBits;
   localparam int RB = sps_pkg::RatingBits;
   localparam int IB = sps_pkg::ItemBits;

   // Stored row memory
   logic [IB+RB-1:0] mem [sps_pkg::MaxEntries];
   logic [IB+RB-1:0] rd_ff;

   logic [LB-1:0] len_ff, ptr_ff, n_ff;
   logic          closed_ff;
   logic [IB-1:0] item_ff;
   logic [RB-1:0] r_ff;
   logic          last_ff, sup_ff;
   logic [sps_pkg::SumBits-1:0] s1_ff, s2_ff;
   logic [sps_pkg::SqBits-1:0]  q1_ff, q2_ff, x_ff;

   logic [sps_pkg::VarBits-1:0]  v1_ff, v2_ff;
   logic [sps_pkg::NumBits-1:0]  a_ff, b_ff;
   logic [sps_pkg::ProdBits-1:0] rem_ff;
   logic [sps_pkg::RootBits-1:0] root_ff;
   logic [6:0]                   sq_cnt_ff;
   logic [sps_pkg::NumBits+14-1:0] num_ff;
   logic [sps_pkg::RootBits:0]   dr_ff;
   logic [sps_pkg::QuoBits:0]    quo_ff;
   logic [6:0]                   dv_cnt_ff;
   logic                         neg_ff;

   logic [IB-1:0] st_item;
   logic [RB-1:0] st_rate;
   logic          match;
   assign st_item = rd_ff[IB+RB-1:RB];
   assign st_rate = rd_ff[RB-1:0];
   assign match   = (st_item == item_ff) && (st_rate != '0);

   assign sts.walk_more = (ptr_ff < len_ff);
   assign sts.stop      = (item_ff < st_item) || match;
   assign sts.rated     = (r_ff != '0);
   assign sts.last      = last_ff;
   assign sts.sqrt_done = (sq_cnt_ff == '0);
   assign sts.div_done  = (dv_cnt_ff == '0);

   // Write stored row
   always_ff @(posedge clock) begin
      if (cmd.load && !(closed_ff ? 1'b0 : (len_ff == LB'(sps_pkg::MaxEntries))))
         mem[closed_ff ? '0 : len_ff[AB-1:0]] <= {in_item, sps_pkg::clamp_rating(in_rating)};
      if (cmd.rd_req) rd_ff <= mem[ptr_ff[AB-1:0]];
   end

   // Capture streamed entry
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= in_item;
         r_ff    <= sps_pkg::clamp_rating(in_rating);
         last_ff <= in_last;
         sup_ff  <= in_suppress;
      end
   end

   // Row length and merge accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; closed_ff <= 1'b0; ptr_ff <= '0; n_ff <= '0;
         s1_ff <= '0; s2_ff <= '0; q1_ff <= '0; q2_ff <= '0; x_ff <= '0;
      end else begin
         if (cmd.load || cmd.clear) begin
            ptr_ff <= '0; n_ff <= '0;
            s1_ff <= '0; s2_ff <= '0; q1_ff <= '0; q2_ff <= '0; x_ff <= '0;
         end
         if (cmd.load) begin
            if (closed_ff) len_ff <= LB'(1);
            else if (len_ff != LB'(sps_pkg::MaxEntries)) len_ff <= len_ff + LB'(1);
            closed_ff <= in_last;
         end
         if (cmd.step && !(item_ff < st_item)) begin
            ptr_ff <= ptr_ff + LB'(1);
            if (match) begin
               n_ff  <= n_ff + LB'(1);
               s1_ff <= s1_ff + sps_pkg::SumBits'(r_ff);
               s2_ff <= s2_ff + sps_pkg::SumBits'(st_rate);
               q1_ff <= q1_ff + sps_pkg::SqBits'(r_ff) * sps_pkg::SqBits'(r_ff);
               q2_ff <= q2_ff + sps_pkg::SqBits'(st_rate) * sps_pkg::SqBits'(st_rate);
               x_ff  <= x_ff + sps_pkg::SqBits'(r_ff) * sps_pkg::SqBits'(st_rate);
            end
         end
      end
   end

   // Each variance term is at most n * sum of squares, below 2^30
   logic [59:0] var_prod;
   assign var_prod = v1_ff[29:0] * v2_ff[29:0];

   // Variance terms, root, then restoring divide
   always_ff @(posedge clock) begin
      if (cmd.fin_start) begin
         v1_ff <= n_ff * q1_ff - s1_ff * s1_ff;
         v2_ff <= n_ff * q2_ff - s2_ff * s2_ff;
         a_ff  <= n_ff * x_ff;
         b_ff  <= s1_ff * s2_ff;
      end
      if (cmd.fin_mul) begin
         neg_ff  <= a_ff < b_ff;
      end
      if (cmd.sqrt_init) begin
         root_ff   <= '0;
         sq_cnt_ff <= 7'd40;
         rem_ff    <= sps_pkg::ProdBits'(var_prod);
         dr_ff     <= '0;
      end else if (cmd.sqrt_step) begin
         // one result bit per cycle, consuming two radicand bits
         if ({dr_ff, rem_ff[79:78]} >= {1'b0, root_ff, 2'b01}) begin
            dr_ff   <= 41'({dr_ff, rem_ff[79:78]} - {1'b0, root_ff, 2'b01});
            root_ff <= {root_ff[38:0], 1'b1};
         end else begin
            dr_ff   <= {dr_ff[38:0], rem_ff[79:78]};
            root_ff <= {root_ff[38:0], 1'b0};
         end
         rem_ff    <= {rem_ff[77:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff - 7'd1;
      end
      if (cmd.div_init) begin
         num_ff    <= (neg_ff ? (b_ff - a_ff) : (a_ff - b_ff)) * 64'(sps_pkg::QOne);
         quo_ff    <= '0;
         dv_cnt_ff <= 7'd64;
         dr_ff     <= '0;
      end else if (cmd.div_step) begin
         if ({dr_ff, num_ff[63]} >= {1'b0, root_ff}) begin
            dr_ff  <= 41'({dr_ff, num_ff[63]} - {1'b0, root_ff});
            quo_ff <= (quo_ff[16] || quo_ff > 17'(sps_pkg::QOne)) ? 17'h1ffff
                      : {quo_ff[15:0], 1'b1};
         end else begin
            dr_ff  <= 41'({dr_ff, num_ff[63]});
            quo_ff <= (quo_ff[16] || quo_ff > 17'(sps_pkg::QOne)) ? 17'h1ffff
                      : {quo_ff[15:0], 1'b0};
         end
         num_ff    <= {num_ff[62:0], 1'b0};
         dv_cnt_ff <= dv_cnt_ff - 7'd1;
      end
   end

   // Result
   logic [15:0] qmag;
   always_comb begin
      qmag = (quo_ff > 17'(sps_pkg::QOne)) ? 16'(sps_pkg::QOne) : quo_ff[15:0];
      count = n_ff;
      if (sup_ff) begin
         sim = '0; undef = 1'b0;
      end else if (n_ff == '0 || root_ff == '0) begin
         sim = '0; undef = 1'b1;
      end else begin
         sim = neg_ff ? -$signed(qmag) : $signed(qmag);
         undef = 1'b0;
      end
   end

   a_ptr_len: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ptr_ff < len_ff) else $error("walk past row");
   a_cnt_ptr: assert property (@(posedge clock) disable iff (reset)
      n_ff <= ptr_ff) else $error("count above pointer");
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LB'(sps_pkg::MaxEntries)) else $error("length overflow");

endmodule

FILE: hw/rtl/sparse_pearson_similarity_unit.sv
// Timing: a load item is stored when accepted; a stream item is captured, then walks stored entries.
// The final item then forms variance terms and runs 40 root steps and 64 quotient steps, one bit each.
// Throughput: one item at a time; the next item waits for the merge walk to finish.
// The result register frees the engine once the item is held for the consumer.
// Synchronous active-high reset clears row length, pointer, sums and control.
// Top level: sparse Pearson similarity over a stored and a streamed rating row.
module sparse_pearson_similarity_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // item_index[12], rating[5], suppress, pad
   input  logic        req_tuser,  // action
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // similarity[16], co_rated_count[11], pad
   output logic        rsp_tuser   // undefined
);

   sps_pkg::sps_cmd_type cmd;
   sps_pkg::sps_sts_type sts;
   logic        fire;
   logic signed [15:0] sim;
   logic [10:0] cnt;
   logic        undef;
   logic        vld_ff;
   logic [31:0] data_ff;
   logic        undef_ff;

   assign fire = req_tvalid && req_tready;

   sps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(fire), .req_action(req_tuser),
      .rsp_busy(vld_ff && !rsp_tready), .sts(sts), .req_ready(req_tready), .cmd(cmd)
   );

   sps_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_item(req_tdata[11:0]), .in_rating(req_tdata[16:12]),
      .in_last(req_tlast), .in_suppress(req_tdata[17]),
      .sts(sts), .sim(sim), .count(cnt), .undef(undef)
   );

   // Hold result item until taken
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.emit) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
      if (cmd.emit) begin
         data_ff  <= {5'b0, cnt, sim};
         undef_ff <= undef;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = undef_ff;

endmodule
